[rtl/aoa_pressure_ratio_filter_macros.svh]
// assertion macros for the angle-of-attack filter checker
// expects clk and rst_n in the scope of use
`ifndef AOA_PRESSURE_RATIO_FILTER_MACROS_SVH
`define AOA_PRESSURE_RATIO_FILTER_MACROS_SVH

// same-cycle implication
`define AOA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aoa filter check failed");

// next-cycle implication
`define AOA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aoa filter check failed");

`endif

[rtl/aoa_prf_pkg.sv]
// shared constants, types and helpers of the angle-of-attack filter
// no dependencies
`timescale 1ns / 1ps

package aoa_prf_pkg;

    localparam int MEDIAN_TAPS  = 5;
    localparam int AVERAGE_TAPS = 8;
    localparam int COUNT_W      = 24;
    localparam int DATA_W       = 32;
    localparam int MED_CNT_W    = $clog2(MEDIAN_TAPS + 1);
    localparam int AVG_CNT_W    = $clog2(AVERAGE_TAPS + 1);
    localparam int IDX_W        = $clog2((MEDIAN_TAPS > AVERAGE_TAPS) ? MEDIAN_TAPS
                                                                      : AVERAGE_TAPS);
    localparam int SUM_W        = DATA_W + $clog2(AVERAGE_TAPS);
    localparam int DIV_NUM_W    = 49;
    localparam int DIV_DEN_W    = 33;
    localparam int DIV_Q_W      = DIV_NUM_W + 1;
    localparam int DIV_STEP_W   = $clog2(DIV_NUM_W + 1);
    localparam int WEIGHT_W     = 17;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CURVE_SLOPE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_OFFSET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_BIAS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 3'd3;

    localparam logic signed [DATA_W-1:0] RST_CURVE_SLOPE  = -32'sd2721186;
    localparam logic signed [DATA_W-1:0] RST_CURVE_OFFSET = 32'sd3088187;
    localparam logic signed [DATA_W-1:0] RST_ANGLE_BIAS   = 32'sd458752;
    localparam logic [WEIGHT_W-1:0]      RST_WEIGHT       = 17'd6554;
    localparam logic [WEIGHT_W-1:0]      WEIGHT_ONE       = 17'h10000;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh80000000;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] sample;
        logic [MED_CNT_W-1:0]     mc;
        logic [AVG_CNT_W-1:0]     ac;
    } win_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [SUM_W-1:0] sum;
    } win_rsp_t;

    typedef struct packed {
        logic                        start;
        logic signed [DIV_NUM_W-1:0] num;
        logic signed [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                      done;
        logic                      fault;
        logic signed [DIV_Q_W-1:0] quo;
    } div_rsp_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        if (v > 64'(SAT_MAX))
            return SAT_MAX;
        else if (v < 64'(SAT_MIN))
            return SAT_MIN;
        else
            return v[DATA_W-1:0];
    endfunction

endpackage

[rtl/aoa_in_if.sv]
// input channel of the angle-of-attack filter: valid, ready, port counts
// depends on aoa_prf_pkg
`timescale 1ns / 1ps

interface aoa_in_if;
    import aoa_prf_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COUNT_W-1:0] fwd_raw_count;
    logic signed [COUNT_W-1:0] fwd_corrected_count;
    logic signed [COUNT_W-1:0] slant_raw_count;
    logic signed [COUNT_W-1:0] slant_corrected_count;

    modport source (output valid, fwd_raw_count, fwd_corrected_count, slant_raw_count,
                    slant_corrected_count, input ready);
    modport sink (input valid, fwd_raw_count, fwd_corrected_count, slant_raw_count,
                  slant_corrected_count, output ready);
endinterface

[rtl/aoa_out_if.sv]
// result channel of the angle-of-attack filter: valid, ready, result fields
// depends on aoa_prf_pkg
`timescale 1ns / 1ps

interface aoa_out_if;
    import aoa_prf_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COUNT_W-1:0] fwd_raw_echo;
    logic signed [COUNT_W-1:0] slant_raw_echo;
    logic signed [DATA_W-1:0]  fwd_filtered;
    logic signed [DATA_W-1:0]  slant_filtered;
    logic signed [DATA_W-1:0]  ratio_fwd_slant;
    logic signed [DATA_W-1:0]  ratio_diff_slant;
    logic signed [DATA_W-1:0]  ratio_slant_sum;
    logic signed [DATA_W-1:0]  ratio_diff_sum;
    logic signed [DATA_W-1:0]  angle_unsmoothed;
    logic signed [DATA_W-1:0]  angle_smoothed;
    logic                      divide_fault;

    modport source (output valid, fwd_raw_echo, slant_raw_echo, fwd_filtered,
                    slant_filtered, ratio_fwd_slant, ratio_diff_slant, ratio_slant_sum,
                    ratio_diff_sum, angle_unsmoothed, angle_smoothed, divide_fault,
                    input ready);
    modport sink (input valid, fwd_raw_echo, slant_raw_echo, fwd_filtered,
                  slant_filtered, ratio_fwd_slant, ratio_diff_slant, ratio_slant_sum,
                  ratio_diff_sum, angle_unsmoothed, angle_smoothed, divide_fault,
                  output ready);
endinterface

[rtl/aoa_window.sv]
// sliding median then sliding sum of one sample stream, one tap per cycle
// depends on aoa_prf_pkg
`timescale 1ns / 1ps

module aoa_window (
    input  logic                   clk,
    input  logic                   rst_n,
    input  aoa_prf_pkg::win_req_t  req,
    output aoa_prf_pkg::win_rsp_t  rsp
);
    import aoa_prf_pkg::*;

    typedef enum logic [3:0] {
        W_IDLE = 4'b0001,
        W_RANK = 4'b0010,
        W_PUSH = 4'b0100,
        W_SUM  = 4'b1000
    } wstate_t;

    wstate_t                  state_reg, state_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic                     done_reg, done_next;
    logic signed [DATA_W-1:0] med_win_reg [MEDIAN_TAPS];
    logic signed [DATA_W-1:0] avg_win_reg [AVERAGE_TAPS];
    logic signed [DATA_W-1:0] med_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [DATA_W-1:0] cand;
    logic [MED_CNT_W-1:0]     rank;
    logic                     hit;

    // rank of the candidate among the filled taps, ties broken by position
    always_comb
    begin
        cand = med_win_reg[idx_reg];
        rank = '0;
        for (int j = 0; j < MEDIAN_TAPS; j++)
        begin
            if ((MED_CNT_W'(j) < req.mc) &&
                ((med_win_reg[j] < cand) ||
                 ((IDX_W'(j) < idx_reg) && (med_win_reg[j] == cand))))
                rank = rank + 1'b1;
        end
        hit = (MED_CNT_W'(idx_reg) < req.mc) && (rank == (req.mc >> 1));
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            W_IDLE:
            begin
                if (req.start)
                begin
                    idx_next   = '0;
                    state_next = W_RANK;
                end
            end
            W_RANK:
            begin
                if (idx_reg == IDX_W'(MEDIAN_TAPS - 1))
                    state_next = W_PUSH;
                else
                    idx_next = idx_reg + 1'b1;
            end
            W_PUSH:
            begin
                idx_next   = '0;
                state_next = W_SUM;
            end
            W_SUM:
            begin
                if (idx_reg == IDX_W'(AVERAGE_TAPS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = W_IDLE;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            default: state_next = W_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == W_IDLE && req.start)
        begin
            for (int i = MEDIAN_TAPS - 1; i > 0; i--)
                med_win_reg[i] <= med_win_reg[i-1];
            med_win_reg[0] <= req.sample;
        end
        if (state_reg == W_RANK && hit)
            med_reg <= cand;
        if (state_reg == W_PUSH)
        begin
            for (int i = AVERAGE_TAPS - 1; i > 0; i--)
                avg_win_reg[i] <= avg_win_reg[i-1];
            avg_win_reg[0] <= med_reg;
            sum_reg        <= '0;
        end
        if (state_reg == W_SUM && ({1'b0, idx_reg} < req.ac))
            sum_reg <= sum_reg + SUM_W'(avg_win_reg[idx_reg]);
    end

    assign rsp.done = done_reg;
    assign rsp.sum  = sum_reg;

endmodule

[rtl/aoa_div.sv]
// signed restoring divider, one quotient bit per cycle, truncates toward zero
// depends on aoa_prf_pkg; a zero divisor saturates by the dividend sign
`timescale 1ns / 1ps

module aoa_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  aoa_prf_pkg::div_req_t  req,
    output aoa_prf_pkg::div_rsp_t  rsp
);
    import aoa_prf_pkg::*;

    logic                      busy_reg;
    logic [DIV_STEP_W-1:0]     step_reg;
    logic                      done_reg;
    logic                      fault_reg;
    logic                      neg_reg;
    logic [DIV_NUM_W-1:0]      q_reg;
    logic [DIV_DEN_W-1:0]      rem_reg;
    logic [DIV_DEN_W-1:0]      dmag_reg;
    logic signed [DIV_Q_W-1:0] quo_reg;
    logic [DIV_NUM_W-1:0]      nmag;
    logic [DIV_DEN_W-1:0]      dmag;
    logic [DIV_DEN_W:0]        rem_shift;
    logic [DIV_DEN_W+1:0]      trial;
    logic [DIV_NUM_W-1:0]      q_next;
    logic [DIV_DEN_W-1:0]      rem_next;

    always_comb
    begin
        nmag      = req.num[DIV_NUM_W-1] ? DIV_NUM_W'(-req.num) : DIV_NUM_W'(req.num);
        dmag      = req.den[DIV_DEN_W-1] ? DIV_DEN_W'(-req.den) : DIV_DEN_W'(req.den);
        rem_shift = {rem_reg, q_reg[DIV_NUM_W-1]};
        trial     = {1'b0, rem_shift} - {2'b00, dmag_reg};
        if (!trial[DIV_DEN_W+1])
        begin
            rem_next = trial[DIV_DEN_W-1:0];
            q_next   = {q_reg[DIV_NUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_shift[DIV_DEN_W-1:0];
            q_next   = {q_reg[DIV_NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == DIV_STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (req.start)
            begin
                if (req.den == '0)
                    done_reg <= 1'b1;
                else
                begin
                    busy_reg <= 1'b1;
                    step_reg <= DIV_STEP_W'(DIV_NUM_W);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
            if (step_reg == DIV_STEP_W'(1))
                quo_reg <= neg_reg ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
        end
        else if (req.start)
        begin
            q_reg     <= nmag;
            rem_reg   <= '0;
            dmag_reg  <= dmag;
            neg_reg   <= req.num[DIV_NUM_W-1] ^ req.den[DIV_DEN_W-1];
            fault_reg <= (req.den == '0);
            if (req.den == '0)
            begin
                priority if (req.num[DIV_NUM_W-1])
                    quo_reg <= DIV_Q_W'(SAT_MIN);
                else if (req.num != '0)
                    quo_reg <= DIV_Q_W'(SAT_MAX);
                else
                    quo_reg <= '0;
            end
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.fault = fault_reg;
    assign rsp.quo   = quo_reg;

endmodule

[rtl/aoa_pressure_ratio_filter.sv]
// channel    | dir | payload
// in_chan    | in  | raw and corrected counts of forward and slant ports
// out_chan   | out | echoes, filtered pressures, four ratios, angles, fault
// cfg port   | in  | cfg_we, cfg_index, cfg_data
// per request: the forward and slant windows, then seven serial divides on the shared
// divider, with the curve and the angle window before the last divide and the
// smoothing after it
// reset clears fills, smoothed angle and handshakes and loads the config defaults; windows fill as used
// a finished result waits in the output register while the next request is taken
`timescale 1ns / 1ps

module aoa_pressure_ratio_filter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    aoa_in_if.sink                               in_chan,
    aoa_out_if.source                            out_chan,
    input  logic                                 cfg_we,
    input  logic [aoa_prf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [aoa_prf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import aoa_prf_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_FILT   = 9'b000000010,
        S_DSTART = 9'b000000100,
        S_DWAIT  = 9'b000001000,
        S_CURVE  = 9'b000010000,
        S_ANGLE  = 9'b000100000,
        S_AWAIT  = 9'b001000000,
        S_MUL    = 9'b010000000,
        S_SUM    = 9'b100000000
    } state_t;

    typedef enum logic [2:0] {
        J_FWD   = 3'd0,
        J_SLANT = 3'd1,
        J_R0    = 3'd2,
        J_R1    = 3'd3,
        J_R2    = 3'd4,
        J_R3    = 3'd5,
        J_ANGLE = 3'd6
    } job_t;

    state_t                     state_reg;
    job_t                       job_reg;
    logic [MED_CNT_W-1:0]       median_fill_reg;
    logic [AVG_CNT_W-1:0]       average_fill_reg;
    logic signed [DATA_W-1:0]   curve_slope_reg;
    logic signed [DATA_W-1:0]   curve_offset_reg;
    logic signed [DATA_W-1:0]   angle_bias_reg;
    logic [WEIGHT_W-1:0]        weight_reg;
    logic signed [DATA_W-1:0]   smooth_reg;
    logic                       out_valid_reg;
    logic                       fault_reg;

    logic signed [COUNT_W-1:0]  fwd_raw_reg, slant_raw_reg;
    logic signed [SUM_W-1:0]    fsum_reg, ssum_reg, asum_reg;
    logic signed [DATA_W-1:0]   fwd_f_reg, sl_f_reg;
    logic signed [DATA_W-1:0]   r0_reg, r1_reg, r2_reg, r3_reg;
    logic signed [DATA_W-1:0]   unsm_reg;
    logic signed [63:0]         prod_reg;
    logic signed [49:0]         p1_reg, p2_reg;

    logic signed [COUNT_W-1:0]  o_fwd_raw_reg, o_slant_raw_reg;
    logic signed [DATA_W-1:0]   o_fwd_f_reg, o_sl_f_reg;
    logic signed [DATA_W-1:0]   o_r0_reg, o_r1_reg, o_r2_reg, o_r3_reg;
    logic signed [DATA_W-1:0]   o_unsm_reg, o_smooth_reg;
    logic                       o_fault_reg;

    win_req_t                   fwd_req, slant_req, ang_req;
    win_rsp_t                   fwd_rsp, slant_rsp, ang_rsp;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    logic                       in_acc;
    logic                       out_load;
    logic signed [DIV_DEN_W-1:0] diff_w, sum_w;
    logic signed [63:0]         quo64;
    logic signed [DATA_W-1:0]   ang;
    logic [WEIGHT_W-1:0]        w_eff;
    logic signed [50:0]         mix;
    logic [MED_CNT_W-1:0]       mc_next;
    logic [AVG_CNT_W-1:0]       ac_next;

    assign in_chan.ready = (state_reg == S_IDLE);
    assign in_acc        = in_chan.valid && in_chan.ready;
    assign out_load      = (state_reg == S_SUM) && (!out_valid_reg || out_chan.ready);

    assign mc_next = (median_fill_reg < MED_CNT_W'(MEDIAN_TAPS)) ? median_fill_reg + 1'b1
                                                                 : MED_CNT_W'(MEDIAN_TAPS);
    assign ac_next = (average_fill_reg < AVG_CNT_W'(AVERAGE_TAPS)) ? average_fill_reg + 1'b1
                                                                   : AVG_CNT_W'(AVERAGE_TAPS);

    assign fwd_req.start   = in_acc;
    assign fwd_req.sample  = DATA_W'(in_chan.fwd_corrected_count);
    assign fwd_req.mc      = median_fill_reg;
    assign fwd_req.ac      = average_fill_reg;
    assign slant_req.start = in_acc;
    assign slant_req.sample = DATA_W'(in_chan.slant_corrected_count);
    assign slant_req.mc    = median_fill_reg;
    assign slant_req.ac    = average_fill_reg;

    assign ang = sat32((prod_reg >>> 16) + 64'(curve_offset_reg));
    assign ang_req.start  = (state_reg == S_ANGLE);
    assign ang_req.sample = ang;
    assign ang_req.mc     = median_fill_reg;
    assign ang_req.ac     = average_fill_reg;

    aoa_window u_fwd_win (.clk(clk), .rst_n(rst_n), .req(fwd_req), .rsp(fwd_rsp));
    aoa_window u_slant_win (.clk(clk), .rst_n(rst_n), .req(slant_req), .rsp(slant_rsp));
    aoa_window u_ang_win (.clk(clk), .rst_n(rst_n), .req(ang_req), .rsp(ang_rsp));
    aoa_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    // divider operands for each job, quotient widening and smoothing mix
    always_comb
    begin
        diff_w = DIV_DEN_W'(sl_f_reg) - DIV_DEN_W'(fwd_f_reg);
        sum_w  = DIV_DEN_W'(sl_f_reg) + DIV_DEN_W'(fwd_f_reg);
        div_req.start = (state_reg == S_DSTART);
        unique case (job_reg)
            J_FWD:
            begin
                div_req.num = DIV_NUM_W'($signed({fsum_reg, 8'd0}));
                div_req.den = DIV_DEN_W'($signed({1'b0, average_fill_reg}));
            end
            J_SLANT:
            begin
                div_req.num = DIV_NUM_W'($signed({ssum_reg, 8'd0}));
                div_req.den = DIV_DEN_W'($signed({1'b0, average_fill_reg}));
            end
            J_R0:
            begin
                div_req.num = DIV_NUM_W'($signed({fwd_f_reg, 16'd0}));
                div_req.den = DIV_DEN_W'(sl_f_reg);
            end
            J_R1:
            begin
                div_req.num = $signed({diff_w, 16'd0});
                div_req.den = DIV_DEN_W'(sl_f_reg);
            end
            J_R2:
            begin
                div_req.num = DIV_NUM_W'($signed({sl_f_reg, 16'd0}));
                div_req.den = sum_w;
            end
            J_R3:
            begin
                div_req.num = $signed({diff_w, 16'd0});
                div_req.den = sum_w;
            end
            J_ANGLE:
            begin
                div_req.num = DIV_NUM_W'(asum_reg);
                div_req.den = DIV_DEN_W'($signed({1'b0, average_fill_reg}));
            end
            default:
            begin
                div_req.num = '0;
                div_req.den = '0;
            end
        endcase
        quo64 = 64'(div_rsp.quo);
        w_eff = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;
        mix   = 51'(p1_reg) + 51'(p2_reg);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            job_reg          <= J_FWD;
            median_fill_reg  <= '0;
            average_fill_reg <= '0;
            curve_slope_reg  <= RST_CURVE_SLOPE;
            curve_offset_reg <= RST_CURVE_OFFSET;
            angle_bias_reg   <= RST_ANGLE_BIAS;
            weight_reg       <= RST_WEIGHT;
            smooth_reg       <= '0;
            out_valid_reg    <= 1'b0;
            fault_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CURVE_SLOPE:      curve_slope_reg  <= cfg_data;
                    REG_CURVE_OFFSET:     curve_offset_reg <= cfg_data;
                    REG_ANGLE_BIAS:       angle_bias_reg   <= cfg_data;
                    REG_SMOOTHING_WEIGHT: weight_reg       <= cfg_data[WEIGHT_W-1:0];
                    default: ;
                endcase
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_chan.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        median_fill_reg  <= mc_next;
                        average_fill_reg <= ac_next;
                        fault_reg        <= 1'b0;
                        state_reg        <= S_FILT;
                    end
                end
                S_FILT:
                begin
                    if (fwd_rsp.done)
                    begin
                        job_reg   <= J_FWD;
                        state_reg <= S_DSTART;
                    end
                end
                S_DSTART: state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        fault_reg <= fault_reg | div_rsp.fault;
                        priority if (job_reg == J_R3)
                            state_reg <= S_CURVE;
                        else if (job_reg == J_ANGLE)
                            state_reg <= S_MUL;
                        else
                        begin
                            job_reg   <= job_t'(job_reg + 3'd1);
                            state_reg <= S_DSTART;
                        end
                    end
                end
                S_CURVE: state_reg <= S_ANGLE;
                S_ANGLE: state_reg <= S_AWAIT;
                S_AWAIT:
                begin
                    if (ang_rsp.done)
                    begin
                        job_reg   <= J_ANGLE;
                        state_reg <= S_DSTART;
                    end
                end
                S_MUL: state_reg <= S_SUM;
                S_SUM:
                begin
                    if (out_load)
                    begin
                        smooth_reg <= sat32(64'(mix >>> 16));
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            fwd_raw_reg   <= in_chan.fwd_raw_count;
            slant_raw_reg <= in_chan.slant_raw_count;
        end
        if (state_reg == S_FILT && fwd_rsp.done)
        begin
            fsum_reg <= fwd_rsp.sum;
            ssum_reg <= slant_rsp.sum;
        end
        if (state_reg == S_AWAIT && ang_rsp.done)
            asum_reg <= ang_rsp.sum;
        if (state_reg == S_DWAIT && div_rsp.done)
        begin
            unique case (job_reg)
                J_FWD:   fwd_f_reg <= sat32(quo64);
                J_SLANT: sl_f_reg  <= sat32(quo64);
                J_R0:    r0_reg    <= sat32(quo64);
                J_R1:    r1_reg    <= sat32(quo64);
                J_R2:    r2_reg    <= sat32(quo64);
                J_R3:    r3_reg    <= sat32(quo64);
                J_ANGLE: unsm_reg  <= sat32(quo64 + 64'(angle_bias_reg));
                default: ;
            endcase
        end
        if (state_reg == S_CURVE)
            prod_reg <= curve_slope_reg * r0_reg;
        if (state_reg == S_MUL)
        begin
            p1_reg <= $signed({1'b0, w_eff}) * unsm_reg;
            p2_reg <= $signed({1'b0, WEIGHT_ONE - w_eff}) * smooth_reg;
        end
        if (out_load)
        begin
            o_fwd_raw_reg   <= fwd_raw_reg;
            o_slant_raw_reg <= slant_raw_reg;
            o_fwd_f_reg     <= fwd_f_reg;
            o_sl_f_reg      <= sl_f_reg;
            o_r0_reg        <= r0_reg;
            o_r1_reg        <= r1_reg;
            o_r2_reg        <= r2_reg;
            o_r3_reg        <= r3_reg;
            o_unsm_reg      <= unsm_reg;
            o_smooth_reg    <= sat32(64'(mix >>> 16));
            o_fault_reg     <= fault_reg;
        end
    end

    assign out_chan.valid            = out_valid_reg;
    assign out_chan.fwd_raw_echo     = o_fwd_raw_reg;
    assign out_chan.slant_raw_echo   = o_slant_raw_reg;
    assign out_chan.fwd_filtered     = o_fwd_f_reg;
    assign out_chan.slant_filtered   = o_sl_f_reg;
    assign out_chan.ratio_fwd_slant  = o_r0_reg;
    assign out_chan.ratio_diff_slant = o_r1_reg;
    assign out_chan.ratio_slant_sum  = o_r2_reg;
    assign out_chan.ratio_diff_sum   = o_r3_reg;
    assign out_chan.angle_unsmoothed = o_unsm_reg;
    assign out_chan.angle_smoothed   = o_smooth_reg;
    assign out_chan.divide_fault     = o_fault_reg;

endmodule

[rtl/aoa_checker.sv]
// port-level checks of the angle-of-attack filter, bound to the top level
// depends on aoa_prf_pkg and aoa_pressure_ratio_filter_macros.svh
`timescale 1ns / 1ps
`include "aoa_pressure_ratio_filter_macros.svh"

module aoa_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [aoa_prf_pkg::DATA_W-1:0] ratio_fwd_slant,
    input logic signed [aoa_prf_pkg::DATA_W-1:0] ratio_slant_sum,
    input logic signed [aoa_prf_pkg::DATA_W-1:0] angle_smoothed,
    input logic                              divide_fault
);
    import aoa_prf_pkg::*;

    logic r0_sat;
    logic r2_sat;

    assign r0_sat = (ratio_fwd_slant == SAT_MAX) || (ratio_fwd_slant == SAT_MIN) ||
                    (ratio_fwd_slant == '0);
    assign r2_sat = (ratio_slant_sum == SAT_MAX) || (ratio_slant_sum == SAT_MIN) ||
                    (ratio_slant_sum == '0);

    // one request in flight at a time
    `AOA_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
    // a result appears only at the end of a request
    `AOA_ASSERT_IMPL(a_result_from_work, $rose(out_valid), $past(!in_ready))
    // a stalled result holds
    `AOA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(angle_smoothed))
    // a fault means a zero divisor saturated one of the two ratios it feeds
    `AOA_ASSERT_IMPL(a_fault_sat, out_valid && divide_fault, r0_sat || r2_sat)

endmodule

bind aoa_pressure_ratio_filter aoa_checker u_aoa_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_chan.valid),
    .in_ready        (in_chan.ready),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .ratio_fwd_slant (out_chan.ratio_fwd_slant),
    .ratio_slant_sum (out_chan.ratio_slant_sum),
    .angle_smoothed  (out_chan.angle_smoothed),
    .divide_fault    (out_chan.divide_fault)
);
